/* src/assert_macros.svh */
// Assertion macros shared by the distance and angle unit.
// Needs nothing else; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define VDA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define VDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/vda_pkg.sv */
// Types, widths and constants of the vector distance and angle unit.
// Depends on nothing; every module of the unit imports it.
package vda_pkg;

	// Configuration of the datapath
	localparam int CORDIC_STEPS = 16;
	localparam int COORD_BITS   = 20;

	// Derived widths
	localparam int DIFF_W      = COORD_BITS + 1;
	localparam int SQ_W        = 2 * COORD_BITS + 1;
	localparam int RAD_W       = 2 * DIFF_W;
	localparam int SQRT_DIGITS = DIFF_W;
	localparam int REM_W       = SQRT_DIGITS + 2;
	localparam int DIST_BITS   = COORD_BITS + 2;
	localparam int DEPTH       = (SQRT_DIGITS > CORDIC_STEPS) ? SQRT_DIGITS : CORDIC_STEPS;
	localparam int GUARD_BITS  = 58 - COORD_BITS;
	localparam int CW          = 64;
	localparam int ACC_W       = 32;
	localparam int ANGLE_W     = 16;

	// Angle accumulator constants: pi and half an output LSB
	localparam logic [ACC_W-1:0] ACC_PI    = 32'h8000_0000;
	localparam logic [ACC_W-1:0] ACC_ROUND = 32'h0000_8000;

	// atan(2^-i) in units of 2pi/2^32
	localparam logic [ACC_W-1:0] ATAN_TAB [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
	} operands_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] distance;
		logic [ANGLE_W-1:0]   angle;
		logic                 zero_vector;
	} result_t;

	typedef struct packed {
		logic             vld;
		logic [RAD_W-1:0] rad;
	} sq_in_t;

	typedef struct packed {
		logic                 vld;
		logic [DIST_BITS-1:0] mag;
	} sq_out_t;

	typedef struct packed {
		logic                     vld;
		logic                     zero;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
	} co_in_t;

	typedef struct packed {
		logic               vld;
		logic               zero;
		logic [ANGLE_W-1:0] angle;
	} co_out_t;

endpackage

/* src/vda_sqrt_pipe.sv */
// Pipelined digit-by-digit square root with round-half-up on the last stage.
// Depends on vda_pkg; one root digit per stage, spare stages only delay.
module vda_sqrt_pipe (
	input  logic            clk,
	input  logic            arst_n,
	input  vda_pkg::sq_in_t sin,
	output vda_pkg::sq_out_t sout
);
	import vda_pkg::*;

	logic                   vld_s  [DEPTH+1];
	logic [RAD_W-1:0]       rad_s  [DEPTH+1];
	logic [REM_W-1:0]       rem_s  [DEPTH+1];
	logic [SQRT_DIGITS-1:0] root_s [DEPTH+1];

	// Stage zero is the incoming radicand
	assign vld_s[0]  = sin.vld;
	assign rad_s[0]  = sin.rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		if (k < SQRT_DIGITS) begin : g_digit
			logic [REM_W+1:0] rem_sh;
			logic [REM_W+1:0] trial;
			logic             take;

			// Bring down the next bit pair and try the digit one
			always_comb begin
				rem_sh = {rem_s[k], rad_s[k][RAD_W-1 -: 2]};
				trial  = {{(REM_W-SQRT_DIGITS){1'b0}}, root_s[k], 2'b01};
				take   = (rem_sh >= trial);
			end

			always_ff @(posedge clk) begin
				rad_s[k+1]  <= {rad_s[k][RAD_W-3:0], 2'b00};
				rem_s[k+1]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
				root_s[k+1] <= {root_s[k][SQRT_DIGITS-2:0], take};
			end
		end else begin : g_hold
			// Hold the finished digits until the angle catches up
			always_ff @(posedge clk) begin
				rad_s[k+1]  <= rad_s[k];
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k];
			end
		end
	end

	// Round: step up when the remainder exceeds the root
	logic                 vld_q;
	logic [DIST_BITS-1:0] dist_q;
	logic [DIST_BITS-1:0] root_ext;

	assign root_ext = DIST_BITS'(root_s[DEPTH]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_s[DEPTH];
		end
	end

	always_ff @(posedge clk) begin
		if (DIST_BITS'(rem_s[DEPTH]) > root_ext) begin
			dist_q <= root_ext + DIST_BITS'(1);
		end else begin
			dist_q <= root_ext;
		end
	end

	assign sout.vld = vld_q;
	assign sout.mag = dist_q;

endmodule

/* src/vda_cordic_pipe.sv */
// Unrolled vectoring CORDIC: one micro-rotation per stage on 64-bit x and y.
// Depends on vda_pkg for the arctangent table and widths.
module vda_cordic_pipe (
	input  logic             clk,
	input  logic             arst_n,
	input  vda_pkg::co_in_t  cin,
	output vda_pkg::co_out_t cout
);
	import vda_pkg::*;

	logic                 vld_s  [DEPTH+1];
	logic                 zero_s [DEPTH+1];
	logic signed [CW-1:0] x_s    [DEPTH+1];
	logic signed [CW-1:0] y_s    [DEPTH+1];
	logic [ACC_W-1:0]     acc_s  [DEPTH+1];

	// Pre-rotation: work on (dx, -dy); turn by pi when dx is negative
	logic                 dneg;
	logic signed [CW-1:0] dx64;
	logic signed [CW-1:0] dy64;

	always_comb begin
		dneg = cin.dx[DIFF_W-1];
		dx64 = {{(CW-DIFF_W){cin.dx[DIFF_W-1]}}, cin.dx};
		dy64 = {{(CW-DIFF_W){cin.dy[DIFF_W-1]}}, cin.dy};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= cin.vld;
		end
	end

	always_ff @(posedge clk) begin
		zero_s[0] <= cin.zero;
		x_s[0]    <= (dneg ? -dx64 : dx64) <<< GUARD_BITS;
		y_s[0]    <= (dneg ? dy64 : -dy64) <<< GUARD_BITS;
		acc_s[0]  <= dneg ? ACC_PI : '0;
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		if (k < CORDIC_STEPS) begin : g_rot
			logic signed [CW-1:0] xs;
			logic signed [CW-1:0] ys;

			assign xs = x_s[k] >>> k;
			assign ys = y_s[k] >>> k;

			// Rotate towards the +x axis, direction from the sign of y
			always_ff @(posedge clk) begin
				zero_s[k+1] <= zero_s[k];
				if (!y_s[k][CW-1]) begin
					x_s[k+1]   <= x_s[k] + ys;
					y_s[k+1]   <= y_s[k] - xs;
					acc_s[k+1] <= acc_s[k] + ATAN_TAB[k];
				end else begin
					x_s[k+1]   <= x_s[k] - ys;
					y_s[k+1]   <= y_s[k] + xs;
					acc_s[k+1] <= acc_s[k] - ATAN_TAB[k];
				end
			end
		end else begin : g_hold
			// Hold the angle until the root is done
			always_ff @(posedge clk) begin
				zero_s[k+1] <= zero_s[k];
				x_s[k+1]    <= x_s[k];
				y_s[k+1]    <= y_s[k];
				acc_s[k+1]  <= acc_s[k];
			end
		end
	end

	// Round the accumulator to the output angle; a zero vector reads as 0
	logic               vld_q;
	logic               zero_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [ACC_W-1:0]   acc_rnd;

	assign acc_rnd = acc_s[DEPTH] + ACC_ROUND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_s[DEPTH];
		end
	end

	always_ff @(posedge clk) begin
		zero_q  <= zero_s[DEPTH];
		angle_q <= zero_s[DEPTH] ? '0 : acc_rnd[ACC_W-1 -: ANGLE_W];
	end

	assign cout.vld   = vld_q;
	assign cout.zero  = zero_q;
	assign cout.angle = angle_q;

endmodule

/* src/vector_distance_and_angle_unit.sv */
// Top level of the vector distance and angle unit.
// Depends on vda_pkg, vda_sqrt_pipe, vda_cordic_pipe and assert_macros.svh.
//
// Usage:
//   Drive a start and an end point on operands and raise start. An operand
//   transfer happens at each rising edge with start high and busy low; busy
//   stays low, so a new pair may be given on every cycle.
//   Each transfer yields one result: distance (rounded integer), angle in
//   units of 2pi/65536 counterclockwise on screen, and zero_vector when the
//   two points coincide (angle and distance then 0).
//   done marks the result for exactly one cycle; the result is taken at the
//   edge that ends that cycle and is not held afterwards.
// Timing:
//   A transfer passes the difference, square and sum registers, DEPTH root
//   stages and a rounding register before done; DEPTH is the larger of the
//   root digit count (COORD_BITS + 1) and CORDIC_STEPS. One item per cycle.
//   The root pipeline, one digit per stage, sets the depth.
// Reset:
//   arst_n clears every valid bit at once; items in flight are dropped.
//   The receiver cannot stall, so nothing waits inside the unit.
`include "assert_macros.svh"

module vector_distance_and_angle_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  vda_pkg::operands_t operands,
	output logic               done,
	output vda_pkg::result_t   result
);
	import vda_pkg::*;

	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: differences end - start, exact in one extra bit
	logic                     vld_s1;
	logic signed [DIFF_W-1:0] dx_s1;
	logic signed [DIFF_W-1:0] dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= {operands.end_x[COORD_BITS-1], operands.end_x}
		       - {operands.start_x[COORD_BITS-1], operands.start_x};
		dy_s1 <= {operands.end_y[COORD_BITS-1], operands.end_y}
		       - {operands.start_y[COORD_BITS-1], operands.start_y};
	end

	// Stage 2: squares of the magnitudes, zero-vector flag
	logic [DIFF_W-1:0]        ax;
	logic [DIFF_W-1:0]        ay;
	logic [2*DIFF_W-1:0]      ax_sq;
	logic [2*DIFF_W-1:0]      ay_sq;
	logic                     vld_s2;
	logic                     zero_s2;
	logic signed [DIFF_W-1:0] dx_s2;
	logic signed [DIFF_W-1:0] dy_s2;
	logic [SQ_W-1:0]          ax_sq_s2;
	logic [SQ_W-1:0]          ay_sq_s2;

	always_comb begin
		ax    = dx_s1[DIFF_W-1] ? DIFF_W'(-dx_s1) : DIFF_W'(dx_s1);
		ay    = dy_s1[DIFF_W-1] ? DIFF_W'(-dy_s1) : DIFF_W'(dy_s1);
		ax_sq = ax * ax;
		ay_sq = ay * ay;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		zero_s2  <= (dx_s1 == '0) && (dy_s1 == '0);
		dx_s2    <= dx_s1;
		dy_s2    <= dy_s1;
		ax_sq_s2 <= ax_sq[SQ_W-1:0];
		ay_sq_s2 <= ay_sq[SQ_W-1:0];
	end

	// Stage 3: squared length
	logic             vld_s3;
	logic [RAD_W-1:0] rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		rad_s3 <= RAD_W'(ax_sq_s2) + RAD_W'(ay_sq_s2);
	end

	// Root and angle pipelines run side by side; the CORDIC has one extra
	// pre-rotation stage, so it starts a stage earlier
	sq_in_t  sq_in;
	sq_out_t sq_out;
	co_in_t  co_in;
	co_out_t co_out;

	assign sq_in.vld = vld_s3;
	assign sq_in.rad = rad_s3;

	assign co_in.vld  = vld_s2;
	assign co_in.zero = zero_s2;
	assign co_in.dx   = dx_s2;
	assign co_in.dy   = dy_s2;

	vda_sqrt_pipe u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.sin    (sq_in),
		.sout   (sq_out)
	);

	vda_cordic_pipe u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cin    (co_in),
		.cout   (co_out)
	);

	// Result transfer
	assign done               = sq_out.vld;
	assign result.distance    = sq_out.mag;
	assign result.angle       = co_out.angle;
	assign result.zero_vector = co_out.zero;

	`VDA_ASSERT_IMPL(a_pipes_aligned, clk, arst_n, 1'b1, sq_out.vld == co_out.vld,
		"root and angle pipelines out of step")
	`VDA_ASSERT_IMPL(a_zero_result, clk, arst_n, done && result.zero_vector,
		(result.distance == '0) && (result.angle == '0), "zero vector with nonzero result")
	`VDA_ASSERT_IMPL(a_nonzero_dist, clk, arst_n, done && !result.zero_vector,
		result.distance != '0, "nonzero vector with zero distance")

endmodule
